// ----- hw/rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the best-fit block allocator
// Defines the payload structs, operation and status codes, sequencer states
// and default configuration values.
// ----------------------------------------------------------------------------
`default_nettype none
package bfa_pkg;
  localparam int POOL_BYTES_DEF    = 65536;
  localparam int GRANULE_BYTES_DEF = 8;
  localparam int CFG_WIDTH         = 13;
  localparam int CFG_IDX_WIDTH     = 1;

  localparam logic [12:0] BLOCK_BYTES_RST  = 13'd64;
  localparam logic [6:0]  HEADER_BYTES_RST = 7'd16;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_BLOCK_BYTES  = 1'b0,
    REG_HEADER_BYTES = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [16:0] request_bytes;
    logic [15:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] grant_address;
    logic [16:0] grant_bytes;
    logic [16:0] used_bytes;
    logic [13:0] live_allocations;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV,
    S_AW_RD, S_AW_EV, S_A_RD, S_A_WR1, S_A_WR2,
    S_F_HRD, S_F_HEV, S_F_WRD, S_F_WEV,
    S_F_PRD, S_F_PEV, S_F_NRD, S_F_NEV, S_F_WR,
    S_RESP
  } state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// bfa_ram: generic single-port RAM with registered read
// One read or write address per cycle; read data appears in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bfa_divider.sv -----
// ----------------------------------------------------------------------------
// bfa_divider: restoring remainder unit
// Computes the remainder of a 17-bit request by the block size, one bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic             rem_zero
);
  logic [16:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [17:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial   = {rem_r[16:0], quo_r[16]};
    done    = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 5'd17;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
      end else begin
        rem_nxt = trial;
      end
      quo_nxt = {quo_r[15:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_nxt = 1'b0;
        done    = 1'b1;
      end
    end
  end

  assign rem_zero = (rem_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/best_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_allocator: best-fit free-list allocator over a byte pool
// Top level: configuration registers, sequencer and header memories.
// ----------------------------------------------------------------------------
// Usage: pulse start with a command while busy is low. The block raises busy
// and later shows exactly one result for one cycle, marked by out_valid; the
// receiver cannot stall it, so capture the result in that cycle. After reset
// the header memories are cleared one granule per cycle while busy stays
// high; configuration writes are taken at any time. An allocate checks its
// size with a bit-serial remainder unit and then walks the free list through
// the single memory port, then writes the headers. A free reads its own
// header, walks the list of free blocks below it, and then reads and writes
// the neighbors. The list walk through the header memory port sets the time
// of each allocate and free.
`default_nettype none
module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int POOL_BYTES    = POOL_BYTES_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_item_t                 in_item,
  output logic                          out_valid,
  output out_item_t                     out_item,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);
  localparam int GRAN   = POOL_BYTES / GRANULE_BYTES;
  localparam int GW     = $clog2(GRAN);
  localparam int LW     = GW + 1;            // link width, holds the null link
  localparam int GSH    = $clog2(GRANULE_BYTES);
  localparam int AW     = GW + GSH + 2;      // byte-address arithmetic width
  localparam logic [LW-1:0] NULL_LINK = LW'(GRAN);

  // Configuration and effective sizes.
  logic [12:0] block_bytes_r;
  logic [6:0]  header_bytes_r;
  logic [13:0] blk_round;
  logic [7:0]  hdr_round;
  logic [16:0] blk_eff, hdr_eff;

  always_comb begin
    blk_round = ({1'b0, block_bytes_r} + 14'(GRANULE_BYTES - 1)) &
                ~14'(GRANULE_BYTES - 1);
    hdr_round = ({1'b0, header_bytes_r} + 8'(GRANULE_BYTES - 1)) &
                ~8'(GRANULE_BYTES - 1);
    blk_eff = (blk_round == '0) ? 17'(GRANULE_BYTES) : 17'(blk_round);
    hdr_eff = (hdr_round == '0) ? 17'(GRANULE_BYTES) : 17'(hdr_round);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r  <= BLOCK_BYTES_RST;
      header_bytes_r <= HEADER_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_BYTES:  block_bytes_r  <= cfg_data[12:0];
        REG_HEADER_BYTES: header_bytes_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Header memories: size and next link share one address.
  logic          mem_we;
  logic [GW-1:0] mem_addr;
  logic [16:0]   size_wdata, size_rdata;
  logic [LW-1:0] next_wdata, next_rdata;

  bfa_ram #(.WIDTH(17), .DEPTH(GRAN)) u_size_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(size_wdata), .rdata(size_rdata)
  );
  bfa_ram #(.WIDTH(LW), .DEPTH(GRAN)) u_next_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(next_wdata), .rdata(next_rdata)
  );

  logic div_start, div_done, div_rem_zero;

  // Sequencer state.
  state_t        state_r, state_nxt;
  in_item_t      in_r, in_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [16:0]   used_r, used_nxt;
  logic [13:0]   count_r, count_nxt;
  logic [GW:0]   clr_r, clr_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0] best_r, best_nxt, bprev_r, bprev_nxt;
  logic [16:0]   bsize_r, bsize_nxt;    // best size / freed block size
  logic [LW-1:0] bnext_r, bnext_nxt;    // best next link
  logic [16:0]   psize_r, psize_nxt;    // size of previous block
  logic [LW-1:0] pnext_r, pnext_nxt;
  logic [LW-1:0] at_r, at_nxt;
  logic [16:0]   asize_r, asize_nxt;
  logic [LW-1:0] anext_r, anext_nxt;
  logic [LW:0]   steps_r, steps_nxt;
  logic [GW-1:0] h_r, h_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic          split_r, split_nxt;
  logic [LW-1:0] newi_r, newi_nxt;
  logic          mrg_r, mrg_nxt;        // free: inserted after the previous block; allocate: previous header read
  out_item_t     out_r, out_nxt;
  logic          oval_r, oval_nxt;

  // Remainder unit for request size checks.
  bfa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_r.request_bytes),
    .divisor(blk_eff), .done(div_done), .rem_zero(div_rem_zero)
  );

  // Address helpers.
  logic [AW-1:0] start_addr, cur_addr, prev_end, at_end, n_addr, new_idx_w;
  logic [AW-1:0] lim;

  always_comb begin
    start_addr = AW'(in_r.free_address) - AW'(hdr_eff);
    cur_addr   = AW'(cur_r) << GSH;
    prev_end   = (AW'(prev_r) << GSH) + AW'(hdr_eff) + AW'(psize_r);
    at_end     = (AW'(at_r) << GSH) + AW'(hdr_eff) + AW'(asize_r);
    n_addr     = AW'(anext_r) << GSH;
    new_idx_w  = AW'(best_r) + ((AW'(hdr_eff) + AW'(in_r.request_bytes)) >> GSH);
    lim        = AW'(GRAN);
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    count_nxt     = count_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    best_nxt      = best_r;
    bprev_nxt     = bprev_r;
    bsize_nxt     = bsize_r;
    bnext_nxt     = bnext_r;
    psize_nxt     = psize_r;
    pnext_nxt     = pnext_r;
    at_nxt        = at_r;
    asize_nxt     = asize_r;
    anext_nxt     = anext_r;
    steps_nxt     = steps_r;
    h_nxt         = h_r;
    end_nxt       = end_r;
    split_nxt     = split_r;
    newi_nxt      = newi_r;
    mrg_nxt       = mrg_r;
    out_nxt       = out_r;
    oval_nxt      = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = cur_r[GW-1:0];
    size_wdata    = '0;
    next_wdata    = '0;
    div_start     = 1'b0;
    busy          = (state_r != S_IDLE);

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r[GW-1:0];
        if (clr_r == '0) begin
          size_wdata = 17'(POOL_BYTES) - hdr_eff;
          next_wdata = NULL_LINK;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (GW+1)'(GRAN - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_item;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        out_nxt = '0;
        cur_nxt   = free_head_r;
        prev_nxt  = NULL_LINK;
        best_nxt  = NULL_LINK;
        bprev_nxt = NULL_LINK;
        steps_nxt = '0;
        case (op_t'(in_r.operation))
          OP_INIT: begin
            mem_we        = 1'b1;
            mem_addr      = '0;
            size_wdata    = 17'(POOL_BYTES) - hdr_eff;
            next_wdata    = NULL_LINK;
            free_head_nxt = '0;
            used_nxt      = hdr_eff;
            count_nxt     = '0;
            out_nxt.status = ST_DONE;
            state_nxt     = S_RESP;
          end
          OP_ALLOC: begin
            if (in_r.request_bytes == '0) begin
              out_nxt.status = ST_BAD;
              state_nxt      = S_RESP;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          OP_FREE: begin
            if (AW'(in_r.free_address) < AW'(hdr_eff) ||
                start_addr[GSH-1:0] != '0 || (start_addr >> GSH) >= lim) begin
              out_nxt.status = ST_BAD;
              state_nxt      = S_RESP;
            end else begin
              h_nxt     = GW'(start_addr >> GSH);
              state_nxt = S_F_HRD;
            end
          end
          default: begin
            out_nxt.status = ST_BAD;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          if (!div_rem_zero) begin
            out_nxt.status = ST_BAD;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_AW_RD;
          end
        end
      end
      // Allocate walk: read current header, then evaluate it.
      S_AW_RD: begin
        if (cur_r < NULL_LINK && steps_r < (LW+1)'(GRAN)) begin
          mem_addr  = cur_r[GW-1:0];
          state_nxt = S_AW_EV;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_AW_EV: begin
        if (size_rdata == in_r.request_bytes) begin
          best_nxt  = cur_r;
          bprev_nxt = prev_r;
          bsize_nxt = size_rdata;
          bnext_nxt = next_rdata;
          state_nxt = S_A_RD;
        end else begin
          if (size_rdata > in_r.request_bytes &&
              (best_r >= NULL_LINK || size_rdata < bsize_r)) begin
            best_nxt  = cur_r;
            bprev_nxt = prev_r;
            bsize_nxt = size_rdata;
            bnext_nxt = next_rdata;
          end
          prev_nxt  = cur_r;
          cur_nxt   = next_rdata;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_AW_RD;
        end
      end
      S_A_RD: begin
        if (best_r >= NULL_LINK) begin
          out_nxt.status = ST_NOFIT;
          state_nxt      = S_RESP;
        end else begin
          split_nxt = ((bsize_r - in_r.request_bytes) >= (hdr_eff + blk_eff)) &&
                      (new_idx_w < lim);
          newi_nxt  = LW'(new_idx_w);
          state_nxt = S_A_WR1;
        end
      end
      S_A_WR1: begin
        // Write the remainder header on a split; update the head if the best block is first.
        if (split_r) begin
          mem_we     = 1'b1;
          mem_addr   = newi_r[GW-1:0];
          size_wdata = bsize_r - in_r.request_bytes - hdr_eff;
          next_wdata = bnext_r;
          used_nxt   = used_r + hdr_eff + in_r.request_bytes;
          out_nxt.grant_bytes = in_r.request_bytes;
          if (bprev_r >= NULL_LINK) free_head_nxt = newi_r;
          else state_nxt = S_A_WR2;
        end else begin
          used_nxt = used_r + bsize_r;
          out_nxt.grant_bytes = bsize_r;
          if (bprev_r >= NULL_LINK) free_head_nxt = bnext_r;
          else state_nxt = S_A_WR2;
        end
        if (bprev_r >= NULL_LINK) state_nxt = S_A_WR2;
        // Previous header must be re-read for its size; link is patched below.
        mem_addr = split_r ? newi_r[GW-1:0] : bprev_r[GW-1:0];
        if (!split_r) mem_we = 1'b0;
      end
      S_A_WR2: begin
        // Read previous header size (registered next cycle) unless at head.
        if (bprev_r < NULL_LINK && !mrg_r) begin
          mem_addr  = bprev_r[GW-1:0];
          mrg_nxt   = 1'b1;
        end else begin
          mrg_nxt   = 1'b0;
          if (bprev_r < NULL_LINK) begin
            mem_we     = 1'b1;
            mem_addr   = bprev_r[GW-1:0];
            size_wdata = size_rdata;
            next_wdata = split_r ? newi_r : bnext_r;
            state_nxt  = S_F_WR;
            at_nxt     = best_r;
          end else begin
            mem_we     = 1'b1;
            mem_addr   = best_r[GW-1:0];
            size_wdata = out_r.grant_bytes;
            next_wdata = NULL_LINK;
            count_nxt  = count_r + 1'b1;
            out_nxt.status = ST_DONE;
            out_nxt.grant_address =
              16'((AW'(best_r) << GSH) + AW'(hdr_eff));
            state_nxt  = S_RESP;
          end
        end
      end
      // Free: read own header.
      S_F_HRD: begin
        mem_addr  = h_r;
        state_nxt = S_F_HEV;
      end
      S_F_HEV: begin
        bsize_nxt = size_rdata;
        end_nxt   = start_addr + AW'(size_rdata) + AW'(hdr_eff);
        state_nxt = S_F_WRD;
      end
      S_F_WRD: begin
        if (cur_r < NULL_LINK && steps_r < (LW+1)'(GRAN) && cur_addr < end_r) begin
          mem_addr  = cur_r[GW-1:0];
          state_nxt = S_F_WEV;
        end else begin
          state_nxt = S_F_PRD;
        end
      end
      S_F_WEV: begin
        psize_nxt = size_rdata;
        pnext_nxt = next_rdata;
        prev_nxt  = cur_r;
        cur_nxt   = next_rdata;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_F_WRD;
      end
      S_F_PRD: begin
        if (prev_r >= NULL_LINK) begin
          mem_we        = 1'b1;
          mem_addr      = h_r;
          size_wdata    = bsize_r;
          next_wdata    = free_head_r;
          free_head_nxt = LW'(h_r);
          used_nxt      = used_r - bsize_r;
          at_nxt        = LW'(h_r);
          asize_nxt     = bsize_r;
          anext_nxt     = free_head_r;
        end else if (prev_end == start_addr) begin
          mem_we     = 1'b1;
          mem_addr   = prev_r[GW-1:0];
          size_wdata = psize_r + hdr_eff + bsize_r;
          next_wdata = pnext_r;
          used_nxt   = used_r - hdr_eff - bsize_r;
          at_nxt     = prev_r;
          asize_nxt  = psize_r + hdr_eff + bsize_r;
          anext_nxt  = pnext_r;
        end else begin
          mem_we     = 1'b1;
          mem_addr   = h_r;
          size_wdata = bsize_r;
          next_wdata = pnext_r;
          used_nxt   = used_r - bsize_r;
          at_nxt     = LW'(h_r);
          asize_nxt  = bsize_r;
          // When the freed block is itself the previous one, it now links to
          // itself.
          anext_nxt  = (prev_r == LW'(h_r)) ? prev_r : pnext_r;
          mrg_nxt    = 1'b1;
        end
        state_nxt = S_F_PEV;
      end
      S_F_PEV: begin
        // Link previous block to the freed one when inserted after it.
        if (mrg_r) begin
          mem_we     = 1'b1;
          mem_addr   = prev_r[GW-1:0];
          size_wdata = psize_r;
          next_wdata = LW'(h_r);
          mrg_nxt    = 1'b0;
        end
        state_nxt = S_F_NRD;
      end
      S_F_NRD: begin
        mem_addr  = anext_r[GW-1:0];
        state_nxt = S_F_NEV;
      end
      S_F_NEV: begin
        if (anext_r < NULL_LINK && at_end == n_addr) begin
          mem_we     = 1'b1;
          mem_addr   = at_r[GW-1:0];
          size_wdata = asize_r + hdr_eff + size_rdata;
          next_wdata = next_rdata;
          used_nxt   = used_r - hdr_eff;
        end
        count_nxt      = count_r - 1'b1;
        out_nxt.status = ST_DONE;
        state_nxt      = S_RESP;
      end
      S_F_WR: begin
        // Allocate with a previous block: write the granted header.
        mem_we     = 1'b1;
        mem_addr   = at_r[GW-1:0];
        size_wdata = out_r.grant_bytes;
        next_wdata = NULL_LINK;
        count_nxt  = count_r + 1'b1;
        out_nxt.status = ST_DONE;
        out_nxt.grant_address = 16'((AW'(at_r) << GSH) + AW'(hdr_eff));
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        out_nxt.used_bytes       = used_r;
        out_nxt.live_allocations = count_r;
        oval_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      used_r      <= 17'(HEADER_BYTES_RST);
      count_r     <= '0;
      oval_r      <= 1'b0;
      mrg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      oval_r      <= oval_nxt;
      mrg_r       <= mrg_nxt;
    end
    in_r    <= in_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    best_r  <= best_nxt;
    bprev_r <= bprev_nxt;
    bsize_r <= bsize_nxt;
    bnext_r <= bnext_nxt;
    psize_r <= psize_nxt;
    pnext_r <= pnext_nxt;
    at_r    <= at_nxt;
    asize_r <= asize_nxt;
    anext_r <= anext_nxt;
    steps_r <= steps_nxt;
    h_r     <= h_nxt;
    end_r   <= end_nxt;
    split_r <= split_nxt;
    newi_r  <= newi_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = oval_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire
